// ----- design/vad_hysteresis_debounce_macros.svh -----
// Assertion macros for the voice activity debounce block.
`ifndef VAD_HYSTERESIS_DEBOUNCE_MACROS_SVH
`define VAD_HYSTERESIS_DEBOUNCE_MACROS_SVH

`ifndef SYNTH

`define VHD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vhd same-cycle check failed");

`define VHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vhd next-cycle check failed");

`else

`define VHD_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define VHD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/vhd_pkg.sv -----
package vhd_pkg;

  localparam int SCORE_FRAC_BITS = 15;
  localparam int SCORE_W         = 16;
  localparam int RUN_W           = 10;
  localparam int SEQ_W           = 32;
  localparam int TIME_W          = 64;
  localparam int ID_W            = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(1 << SCORE_FRAC_BITS);
  localparam logic [RUN_W-1:0]   MAX_RUN   = RUN_W'(1000);

  localparam logic [SCORE_W-1:0] START_THR_RST    = SCORE_W'(19661);
  localparam logic [SCORE_W-1:0] END_THR_RST      = SCORE_W'(11469);
  localparam logic [RUN_W-1:0]   START_FRAMES_RST = RUN_W'(3);
  localparam logic [RUN_W-1:0]   END_FRAMES_RST   = RUN_W'(10);

  localparam logic [CFG_IDX_W-1:0] CFG_START_THR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_THR      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_FRAMES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_FRAMES   = 2'd3;

  localparam logic EV_KIND_START = 1'b0;
  localparam logic EV_KIND_END   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_REJECTED     = 2'd1,
    ST_BACKEND_FAIL = 2'd2,
    ST_SCORE_RANGE  = 2'd3
  } status_t;

  typedef struct packed {
    logic                 event_valid;
    logic                 event_kind;
    logic [ID_W-1:0]      event_number;
    logic [ID_W-1:0]      segment_number;
    logic [SEQ_W-1:0]     event_frame_seq;
    logic [TIME_W-1:0]    event_time;
    logic [SCORE_W-1:0]   event_score;
    logic                 in_speech;
    logic [RUN_W-1:0]     start_run;
    logic [RUN_W-1:0]     end_run;
    status_t              status;
  } res_t;

  function automatic logic [RUN_W-1:0] run_bump(input logic [RUN_W-1:0] n);
    run_bump = (n >= MAX_RUN) ? MAX_RUN : n + RUN_W'(1);
  endfunction

endpackage

// ----- design/vhd_in_if.sv -----
interface vhd_in_if;
  logic                          valid;
  logic                          ready;
  logic [vhd_pkg::SCORE_W-1:0]   frame_score;
  logic [vhd_pkg::SEQ_W-1:0]     frame_seq;
  logic [vhd_pkg::TIME_W-1:0]    capture_time;
  logic                          frame_ok;
  logic                          backend_failed;

  modport source (
    output valid, frame_score, frame_seq, capture_time, frame_ok, backend_failed,
    input  ready
  );

  modport sink (
    input  valid, frame_score, frame_seq, capture_time, frame_ok, backend_failed,
    output ready
  );
endinterface

// ----- design/vhd_out_if.sv -----
interface vhd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          event_valid;
  logic                          event_kind;
  logic [vhd_pkg::ID_W-1:0]      event_number;
  logic [vhd_pkg::ID_W-1:0]      segment_number;
  logic [vhd_pkg::SEQ_W-1:0]     event_frame_seq;
  logic [vhd_pkg::TIME_W-1:0]    event_time;
  logic [vhd_pkg::SCORE_W-1:0]   event_score;
  logic                          in_speech;
  logic [vhd_pkg::RUN_W-1:0]     start_run;
  logic [vhd_pkg::RUN_W-1:0]     end_run;
  logic [1:0]                    status;

  modport source (
    output valid, event_valid, event_kind, event_number, segment_number, event_frame_seq,
           event_time, event_score, in_speech, start_run, end_run, status,
    input  ready
  );

  modport sink (
    input  valid, event_valid, event_kind, event_number, segment_number, event_frame_seq,
           event_time, event_score, in_speech, start_run, end_run, status,
    output ready
  );
endinterface

// ----- design/vad_hysteresis_debounce.sv -----
// Speech/silence hysteresis detector with debounce run counters. Each input beat carries
// one frame score and yields exactly one result beat. A beat is taken into an input
// register, evaluated there against the detector state and written into a two-entry
// result queue once the queue has a free entry, so its result reaches the output through
// the input register and the queue entry in that order. The block takes one beat per
// cycle for as long as results are taken; in_ch.ready comes from registers only and drops
// while the input register is holding a beat and the result queue is full. Configuration
// writes take effect at once and belong to idle periods.
`include "vad_hysteresis_debounce_macros.svh"

module vad_hysteresis_debounce (
  input  logic                               clk,
  input  logic                               rst_n,
  vhd_in_if.sink                             in_ch,
  vhd_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [vhd_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [vhd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [vhd_pkg::SCORE_W-1:0] start_thr_r;
  logic [vhd_pkg::SCORE_W-1:0] end_thr_r;
  logic [vhd_pkg::RUN_W-1:0]   start_frames_r;
  logic [vhd_pkg::RUN_W-1:0]   end_frames_r;

  logic                        speech_r, speech_nxt;
  logic [vhd_pkg::RUN_W-1:0]   start_cnt_r, start_cnt_nxt;
  logic [vhd_pkg::RUN_W-1:0]   end_cnt_r, end_cnt_nxt;
  logic [vhd_pkg::ID_W-1:0]    evt_num_r, evt_num_nxt;
  logic [vhd_pkg::ID_W-1:0]    last_seg_r, last_seg_nxt;
  logic [vhd_pkg::ID_W-1:0]    open_seg_r, open_seg_nxt;

  logic                        in_valid_r, in_valid_nxt;
  logic [vhd_pkg::SCORE_W-1:0] score_r;
  logic [vhd_pkg::SEQ_W-1:0]   seq_r;
  logic [vhd_pkg::TIME_W-1:0]  time_r;
  logic                        ok_r;
  logic                        failed_r;

  vhd_pkg::res_t               q_r [2];
  logic                        wr_ptr_r, rd_ptr_r;
  logic [1:0]                  cnt_r, cnt_nxt;

  vhd_pkg::res_t               res;
  vhd_pkg::res_t               head;
  logic                        ev;
  logic                        load;
  logic                        push;
  logic                        pop;
  logic                        q_full;

  assign q_full      = (cnt_r == 2'd2);
  assign in_ch.ready = !in_valid_r || !q_full;
  assign load        = in_ch.valid && in_ch.ready;
  assign push        = in_valid_r && !q_full;
  assign pop         = out_ch.valid && out_ch.ready;
  assign in_valid_nxt = load || (in_valid_r && !push);

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_comb begin
    speech_nxt    = speech_r;
    start_cnt_nxt = start_cnt_r;
    end_cnt_nxt   = end_cnt_r;
    evt_num_nxt   = evt_num_r;
    last_seg_nxt  = last_seg_r;
    open_seg_nxt  = open_seg_r;
    ev            = 1'b0;
    res           = '0;
    res.status    = vhd_pkg::ST_OK;

    if (!ok_r) begin
      res.status = vhd_pkg::ST_REJECTED;
    end else if (failed_r) begin
      res.status    = vhd_pkg::ST_BACKEND_FAIL;
      start_cnt_nxt = '0;
      end_cnt_nxt   = '0;
    end else if (score_r > vhd_pkg::SCORE_ONE) begin
      res.status    = vhd_pkg::ST_SCORE_RANGE;
      start_cnt_nxt = '0;
      end_cnt_nxt   = '0;
    end else if (!speech_r) begin
      end_cnt_nxt = '0;
      if (score_r >= start_thr_r) begin
        start_cnt_nxt = vhd_pkg::run_bump(start_cnt_r);
        if (start_cnt_nxt >= start_frames_r) begin
          ev                 = 1'b1;
          res.event_kind     = vhd_pkg::EV_KIND_START;
          last_seg_nxt       = last_seg_r + vhd_pkg::ID_W'(1);
          open_seg_nxt       = last_seg_nxt;
          res.segment_number = last_seg_nxt;
          speech_nxt         = 1'b1;
        end
      end else begin
        start_cnt_nxt = '0;
      end
    end else begin
      start_cnt_nxt = '0;
      if (score_r <= end_thr_r) begin
        end_cnt_nxt = vhd_pkg::run_bump(end_cnt_r);
        if (end_cnt_nxt >= end_frames_r) begin
          ev                 = 1'b1;
          res.event_kind     = vhd_pkg::EV_KIND_END;
          res.segment_number = open_seg_r;
          speech_nxt         = 1'b0;
          open_seg_nxt       = '0;
        end
      end else begin
        end_cnt_nxt = '0;
      end
    end

    if (ev) begin
      evt_num_nxt         = evt_num_r + vhd_pkg::ID_W'(1);
      start_cnt_nxt       = '0;
      end_cnt_nxt         = '0;
      res.event_valid     = 1'b1;
      res.event_number    = evt_num_nxt;
      res.event_frame_seq = seq_r;
      res.event_time      = time_r;
      res.event_score     = score_r;
    end

    res.in_speech = speech_nxt;
    res.start_run = start_cnt_nxt;
    res.end_run   = end_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_thr_r    <= vhd_pkg::START_THR_RST;
      end_thr_r      <= vhd_pkg::END_THR_RST;
      start_frames_r <= vhd_pkg::START_FRAMES_RST;
      end_frames_r   <= vhd_pkg::END_FRAMES_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        vhd_pkg::CFG_START_THR:    start_thr_r    <= cfg_data;
        vhd_pkg::CFG_END_THR:      end_thr_r      <= cfg_data;
        vhd_pkg::CFG_START_FRAMES: start_frames_r <= cfg_data[vhd_pkg::RUN_W-1:0];
        vhd_pkg::CFG_END_FRAMES:   end_frames_r   <= cfg_data[vhd_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speech_r    <= 1'b0;
      start_cnt_r <= '0;
      end_cnt_r   <= '0;
      evt_num_r   <= '0;
      last_seg_r  <= '0;
      open_seg_r  <= '0;
      in_valid_r  <= 1'b0;
      wr_ptr_r    <= 1'b0;
      rd_ptr_r    <= 1'b0;
      cnt_r       <= 2'd0;
    end else begin
      in_valid_r <= in_valid_nxt;
      cnt_r      <= cnt_nxt;
      if (push) begin
        speech_r    <= speech_nxt;
        start_cnt_r <= start_cnt_nxt;
        end_cnt_r   <= end_cnt_nxt;
        evt_num_r   <= evt_num_nxt;
        last_seg_r  <= last_seg_nxt;
        open_seg_r  <= open_seg_nxt;
        wr_ptr_r    <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      score_r  <= in_ch.frame_score;
      seq_r    <= in_ch.frame_seq;
      time_r   <= in_ch.capture_time;
      ok_r     <= in_ch.frame_ok;
      failed_r <= in_ch.backend_failed;
    end
    if (push) begin
      q_r[wr_ptr_r] <= res;
    end
  end

  assign head = q_r[rd_ptr_r];

  assign out_ch.valid           = (cnt_r != 2'd0);
  assign out_ch.event_valid     = head.event_valid;
  assign out_ch.event_kind      = head.event_kind;
  assign out_ch.event_number    = head.event_number;
  assign out_ch.segment_number  = head.segment_number;
  assign out_ch.event_frame_seq = head.event_frame_seq;
  assign out_ch.event_time      = head.event_time;
  assign out_ch.event_score     = head.event_score;
  assign out_ch.in_speech       = head.in_speech;
  assign out_ch.start_run       = head.start_run;
  assign out_ch.end_run         = head.end_run;
  assign out_ch.status          = head.status;

  `VHD_ASSERT_SAME(a_q_bound, clk, rst_n, 1'b1, cnt_r != 2'd3)
  `VHD_ASSERT_SAME(a_speech_no_start, clk, rst_n, speech_r, start_cnt_r == '0)
  `VHD_ASSERT_SAME(a_silence_closed, clk, rst_n, !speech_r,
                   (end_cnt_r == '0) && (open_seg_r == '0))
  `VHD_ASSERT_NEXT(a_evt_step, clk, rst_n, push && ev, evt_num_r == $past(evt_num_r) + 32'd1)

endmodule
